FILE: rtl/ffd_pkg.sv
// ffd_pkg: field widths, bus layout, operation and register codes of the
// farrow fractional-delay fir
// no dependencies
package ffd_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 16;   // q1.15 samples and output
    localparam int COEF_W   = 18;   // q2.16 coefficients and gain
    localparam int MU_W     = 16;   // q1.15 delay
    localparam int X_W      = 17;   // negated delay, holds +1.0 exactly
    localparam int TAPS_W   = 5;
    localparam int ORDER_W  = 2;
    localparam int TIDX_W   = 4;
    localparam int PIDX_W   = 2;

    // slave tdata layout, lowest bit up
    localparam int S_SAMPLE_LSB = 0;
    localparam int S_TAP_LSB    = S_SAMPLE_LSB + SAMPLE_W;
    localparam int S_POWER_LSB  = S_TAP_LSB + TIDX_W;
    localparam int S_COEF_LSB   = S_POWER_LSB + PIDX_W;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 16;

    // apb
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // rounding constants
    localparam int HALF_Q15 = 16384;
    localparam int HALF_Q16 = 32768;
    localparam int OUT_MAX  = 32767;
    localparam int OUT_MIN  = -32768;

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        REG_DELAY_MU    = 2'd0,
        REG_DC_GAIN_INV = 2'd1,
        REG_ACTIVE_TAPS = 2'd2,
        REG_POLY_ORDER  = 2'd3
    } reg_idx_t;

endpackage

FILE: rtl/farrow_fractional_delay_fir.sv
// farrow_fractional_delay_fir: top level, sequencer around one shared multiplier
// with coefficient and sample memories and an apb register file
// depends on ffd_pkg

// Farrow fractional-delay filter. A load item (tuser operation 0) writes one
// q2.16 coefficient for one tap and power into the coefficient memory and
// gives no result. A sample item (operation 1) pushes its q1.15
// sample into the window and gives one result: for each tap the polynomial
// in x = -delay_mu is worked by horner, scaled by dc_gain_inverse, and
// multiplied by the matching window sample; the sum is rounded half up to
// q1.15 and clipped, with tuser flagging a clip. Every multiply goes through
// one shared multiplier, so a sample item holds the input until its result is
// in the output register; the next item is taken while the result still
// waits there. Coefficients must be loaded before use, the window starts out
// cleared. The user must write registers over apb only while no sample item
// is in flight; the block itself does not enforce this.
module farrow_fractional_delay_fir
#(
    parameter int MAX_TAPS  = 16,
    parameter int MAX_ORDER = 3
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // sample_in[15:0], tap_index[19:16], power_index[21:20], coefficient[39:22]
    input  logic [ffd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // operation[0]
    input  logic [0:0]                    s_axis_tuser,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // filtered_sample[15:0]
    output logic [ffd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // saturated[0]
    output logic [0:0]                    m_axis_tuser,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffd_pkg::APB_AW-1:0]    paddr,
    input  logic [ffd_pkg::APB_DW-1:0]    pwdata,
    output logic [ffd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    // sizes that follow from the parameters
    localparam int TAP_AW = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int ORD_W  = $clog2(MAX_ORDER + 1);
    localparam int ACC_W  = ffd_pkg::COEF_W + ORD_W + 1;   // horner accumulator
    localparam int TAP_W  = ACC_W + 2;                      // scaled tap
    localparam int MUL_BW = ffd_pkg::COEF_W;                // widest b operand
    localparam int P_W    = TAP_W + MUL_BW;                 // product
    localparam int SUM_W  = P_W + $clog2(MAX_TAPS);         // tap sum
    localparam int COEF_DEPTH = MAX_TAPS * (2 ** ORD_W);

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_RD_TOP,   // read highest power coefficient
        ST_LD_TOP,   // start horner with it
        ST_MUL_X,    // acc * x
        ST_ADD_C,    // round and add next lower coefficient
        ST_MUL_G,    // acc * gain
        ST_TAP,      // round to tap
        ST_MUL_S,    // tap * sample
        ST_ACC_S,    // accumulate
        ST_FIN       // round, clip, hand to output register
    } state_t;

    // control
    state_t                       state_reg, state_next;
    logic [TAP_AW-1:0]            i_reg, i_next;
    logic [ORD_W-1:0]             k_reg, k_next;
    logic [CNT_W-1:0]             n_reg, n_next;
    logic [ORD_W-1:0]             q_reg, q_next;
    logic [TAP_AW-1:0]            slot_reg, slot_next;
    logic [TAP_AW-1:0]            wp_reg, wp_next;
    logic [MAX_TAPS-1:0]          win_vld_reg, win_vld_next;
    logic                         out_valid_reg, out_valid_next;

    // datapath
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic signed [P_W-1:0]        prod_reg, prod_next;
    logic signed [TAP_W-1:0]      tap_reg, tap_next;
    logic signed [SUM_W-1:0]      sum_reg, sum_next;
    logic [ffd_pkg::SAMPLE_W-1:0] out_data_reg, out_data_next;
    logic                         out_sat_reg, out_sat_next;

    // configuration
    logic [ffd_pkg::MU_W-1:0]     mu_reg, mu_next;
    logic [ffd_pkg::COEF_W-1:0]   gain_reg, gain_next;
    logic [ffd_pkg::TAPS_W-1:0]   taps_reg, taps_next;
    logic [ffd_pkg::ORDER_W-1:0]  order_reg, order_next;

    // memories
    logic [ffd_pkg::COEF_W-1:0]   coef_mem [COEF_DEPTH];
    logic [ffd_pkg::SAMPLE_W-1:0] win_mem  [MAX_TAPS];
    logic signed [ffd_pkg::COEF_W-1:0]   coef_rd_reg;
    logic signed [ffd_pkg::SAMPLE_W-1:0] win_rd_reg;

    // input fields
    ffd_pkg::op_t                 in_op;
    logic [ffd_pkg::SAMPLE_W-1:0] in_sample;
    logic [ffd_pkg::TIDX_W-1:0]   in_tap;
    logic [ffd_pkg::PIDX_W-1:0]   in_power;
    logic [ffd_pkg::COEF_W-1:0]   in_coef;

    logic                         s_fire;
    logic                         cfg_wr;
    ffd_pkg::reg_idx_t            cfg_idx;

    // helpers
    logic [TAP_AW+ffd_pkg::TIDX_W-1:0] tap_wide;
    logic [ORD_W+ffd_pkg::PIDX_W-1:0]  pow_wide;
    logic                              load_ok;
    logic [TAP_AW+ORD_W-1:0]           coef_waddr;
    logic [TAP_AW+ORD_W-1:0]           coef_raddr;
    logic [ORD_W-1:0]                  coef_rpow;
    int                                n_int;
    int                                q_int;
    logic [CNT_W-1:0]                  n_clamp;
    logic [ORD_W-1:0]                  q_clamp;
    logic [TAP_AW-1:0]                 wp_inc;
    logic [TAP_AW+1:0]                 base_sum;
    logic [TAP_AW-1:0]                 base_slot;
    logic                              last_tap;

    logic signed [ffd_pkg::X_W-1:0]    x_val;
    logic signed [TAP_W-1:0]           mul_a;
    logic signed [MUL_BW-1:0]          mul_b;
    logic signed [P_W-1:0]             mul_out;
    logic signed [P_W-1:0]             prod_rnd15;
    logic signed [P_W-1:0]             prod_rnd16;
    logic signed [SUM_W-1:0]           y_full;
    logic                              y_hi;
    logic                              y_lo;

    assign in_op     = ffd_pkg::op_t'(s_axis_tuser[0]);
    assign in_sample = s_axis_tdata[ffd_pkg::S_SAMPLE_LSB +: ffd_pkg::SAMPLE_W];
    assign in_tap    = s_axis_tdata[ffd_pkg::S_TAP_LSB +: ffd_pkg::TIDX_W];
    assign in_power  = s_axis_tdata[ffd_pkg::S_POWER_LSB +: ffd_pkg::PIDX_W];
    assign in_coef   = s_axis_tdata[ffd_pkg::S_COEF_LSB +: ffd_pkg::COEF_W];

    // one item at a time; the output register decouples the result side
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_sat_reg;

    // apb, no wait states
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = ffd_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        unique case (cfg_idx)
            ffd_pkg::REG_DELAY_MU:
                prdata = ffd_pkg::APB_DW'($signed(mu_reg));
            ffd_pkg::REG_DC_GAIN_INV:
                prdata = ffd_pkg::APB_DW'($signed(gain_reg));
            ffd_pkg::REG_ACTIVE_TAPS:
                prdata = ffd_pkg::APB_DW'(taps_reg);
            ffd_pkg::REG_POLY_ORDER:
                prdata = ffd_pkg::APB_DW'(order_reg);
            default:
                prdata = '0;
        endcase
    end

    // load address; out-of-range loads are dropped
    assign tap_wide   = {{TAP_AW{1'b0}}, in_tap};
    assign pow_wide   = {{ORD_W{1'b0}}, in_power};
    assign load_ok    = (int'(in_tap) < MAX_TAPS) && (int'(in_power) <= MAX_ORDER);
    assign coef_waddr = {tap_wide[TAP_AW-1:0], pow_wide[ORD_W-1:0]};

    // read address follows the horner step
    assign coef_rpow  = (state_reg == ST_RD_TOP) ? q_reg : (k_reg - ORD_W'(1));
    assign coef_raddr = {i_reg, coef_rpow};

    // length and order clamps
    always_comb
    begin
        n_int = int'(taps_reg);
        if (n_int < 2)
            n_int = 2;
        if (n_int > MAX_TAPS)
            n_int = MAX_TAPS;
        q_int = int'(order_reg);
        if (q_int < 1)
            q_int = 1;
        if (q_int > MAX_ORDER)
            q_int = MAX_ORDER;
    end

    assign n_clamp = CNT_W'(n_int);
    assign q_clamp = ORD_W'(q_int);

    // oldest of the last n samples, counted after this push
    assign wp_inc    = (int'(wp_reg) == MAX_TAPS - 1) ? '0 : (wp_reg + TAP_AW'(1));
    assign base_sum  = (TAP_AW+2)'(wp_inc) + (TAP_AW+2)'(MAX_TAPS) - (TAP_AW+2)'(n_clamp);
    assign base_slot = (int'(base_sum) >= MAX_TAPS) ?
                       TAP_AW'(base_sum - (TAP_AW+2)'(MAX_TAPS)) : TAP_AW'(base_sum);

    assign last_tap = (int'(i_reg) == int'(n_reg) - 1);

    // shared multiplier
    assign x_val = -(ffd_pkg::X_W'($signed(mu_reg)));

    always_comb
    begin
        case (state_reg)
            ST_MUL_S:
            begin
                mul_a = tap_reg;
                mul_b = MUL_BW'(win_rd_reg);
            end
            ST_MUL_G:
            begin
                mul_a = TAP_W'(acc_reg);
                mul_b = $signed(gain_reg);
            end
            default:
            begin
                mul_a = TAP_W'(acc_reg);
                mul_b = MUL_BW'(x_val);
            end
        endcase
    end

    assign mul_out = mul_a * mul_b;

    // round half up by adding half an lsb and shifting
    assign prod_rnd15 = (prod_reg + P_W'(ffd_pkg::HALF_Q15)) >>> 15;
    assign prod_rnd16 = (prod_reg + P_W'(ffd_pkg::HALF_Q16)) >>> 16;
    assign y_full     = (sum_reg + SUM_W'(ffd_pkg::HALF_Q16)) >>> 16;
    assign y_hi       = (y_full > SUM_W'(ffd_pkg::OUT_MAX));
    assign y_lo       = (y_full < SUM_W'(ffd_pkg::OUT_MIN));

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        q_next         = q_reg;
        slot_next      = slot_reg;
        wp_next        = wp_reg;
        win_vld_next   = win_vld_reg;
        out_valid_next = out_valid_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        tap_next       = tap_reg;
        sum_next       = sum_reg;
        out_data_next  = out_data_reg;
        out_sat_next   = out_sat_reg;
        mu_next        = mu_reg;
        gain_next      = gain_reg;
        taps_next      = taps_reg;
        order_next     = order_reg;

        if (cfg_wr)
        begin
            unique case (cfg_idx)
                ffd_pkg::REG_DELAY_MU:    mu_next    = pwdata[ffd_pkg::MU_W-1:0];
                ffd_pkg::REG_DC_GAIN_INV: gain_next  = pwdata[ffd_pkg::COEF_W-1:0];
                ffd_pkg::REG_ACTIVE_TAPS: taps_next  = pwdata[ffd_pkg::TAPS_W-1:0];
                ffd_pkg::REG_POLY_ORDER:  order_next = pwdata[ffd_pkg::ORDER_W-1:0];
                default:                  mu_next    = mu_reg;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (in_op == ffd_pkg::OP_SAMPLE))
                begin
                    win_vld_next[wp_reg] = 1'b1;
                    wp_next    = wp_inc;
                    n_next     = n_clamp;
                    q_next     = q_clamp;
                    i_next     = '0;
                    slot_next  = base_slot;
                    sum_next   = '0;
                    state_next = ST_RD_TOP;
                end
            end
            ST_RD_TOP:
            begin
                k_next     = q_reg;
                state_next = ST_LD_TOP;
            end
            ST_LD_TOP:
            begin
                acc_next   = ACC_W'(coef_rd_reg);
                state_next = ST_MUL_X;
            end
            ST_MUL_X:
            begin
                prod_next  = mul_out;
                state_next = ST_ADD_C;
            end
            ST_ADD_C:
            begin
                acc_next   = ACC_W'(prod_rnd15) + ACC_W'(coef_rd_reg);
                k_next     = k_reg - ORD_W'(1);
                state_next = (k_reg == ORD_W'(1)) ? ST_MUL_G : ST_MUL_X;
            end
            ST_MUL_G:
            begin
                prod_next  = mul_out;
                state_next = ST_TAP;
            end
            ST_TAP:
            begin
                tap_next   = TAP_W'(prod_rnd16);
                state_next = ST_MUL_S;
            end
            ST_MUL_S:
            begin
                prod_next  = mul_out;
                state_next = ST_ACC_S;
            end
            ST_ACC_S:
            begin
                sum_next = sum_reg + SUM_W'(prod_reg);
                if (last_tap)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    i_next     = i_reg + TAP_AW'(1);
                    slot_next  = (int'(slot_reg) == MAX_TAPS - 1) ?
                                 '0 : (slot_reg + TAP_AW'(1));
                    state_next = ST_RD_TOP;
                end
            end
            ST_FIN:
            begin
                // wait here while an earlier result is still unclaimed
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_sat_next   = y_hi || y_lo;
                    if (y_hi)
                        out_data_next = ffd_pkg::SAMPLE_W'(ffd_pkg::OUT_MAX);
                    else if (y_lo)
                        out_data_next = ffd_pkg::SAMPLE_W'(ffd_pkg::OUT_MIN);
                    else
                        out_data_next = ffd_pkg::SAMPLE_W'(y_full);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            q_reg         <= '0;
            slot_reg      <= '0;
            wp_reg        <= '0;
            win_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            prod_reg      <= '0;
            tap_reg       <= '0;
            sum_reg       <= '0;
            out_data_reg  <= '0;
            out_sat_reg   <= 1'b0;
            mu_reg        <= '0;
            gain_reg      <= ffd_pkg::COEF_W'(65536);
            taps_reg      <= ffd_pkg::TAPS_W'(16);
            order_reg     <= ffd_pkg::ORDER_W'(3);
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            q_reg         <= q_next;
            slot_reg      <= slot_next;
            wp_reg        <= wp_next;
            win_vld_reg   <= win_vld_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            prod_reg      <= prod_next;
            tap_reg       <= tap_next;
            sum_reg       <= sum_next;
            out_data_reg  <= out_data_next;
            out_sat_reg   <= out_sat_next;
            mu_reg        <= mu_next;
            gain_reg      <= gain_next;
            taps_reg      <= taps_next;
            order_reg     <= order_next;
        end
    end

    // coefficient memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (s_fire && (in_op == ffd_pkg::OP_LOAD) && load_ok)
            coef_mem[coef_waddr] <= in_coef;
        coef_rd_reg <= $signed(coef_mem[coef_raddr]);
    end

    // sample window; slots never written read as zero
    always_ff @(posedge clk)
    begin
        if (s_fire && (in_op == ffd_pkg::OP_SAMPLE))
            win_mem[wp_reg] <= in_sample;
        win_rd_reg <= win_vld_reg[slot_reg] ? $signed(win_mem[slot_reg]) : '0;
    end

    // a sample item always starts the tap loop
    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (in_op == ffd_pkg::OP_SAMPLE)) |=> (state_reg == ST_RD_TOP))
        else $error("sample item did not start the tap loop");

    // a load item leaves the sequencer idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (in_op == ffd_pkg::OP_LOAD)) |=> (state_reg == ST_IDLE))
        else $error("load item disturbed the sequencer");

    // horner step never runs past the clamped order
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MUL_X) || (state_reg == ST_ADD_C)) |->
        ((k_reg != '0) && (k_reg <= q_reg)))
        else $error("horner step out of range");

    // tap counter stays inside the active length
    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (int'(i_reg) < int'(n_reg)))
        else $error("tap counter past active length");

    // window read slot wraps inside the window
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(slot_reg) < MAX_TAPS) && (int'(wp_reg) < MAX_TAPS))
        else $error("window pointer out of range");

    // a new result appears only from the final state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result raised outside the final state");

endmodule
